// ----- rtl/rpn_pkg.sv -----
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared constants, codes and interface structs for the RPN stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    // Operation codes (anything above OP_CLEAR is unknown)
    localparam logic [3:0] OP_PUSH  = 4'd0;
    localparam logic [3:0] OP_ADD   = 4'd1;
    localparam logic [3:0] OP_SUB   = 4'd2;
    localparam logic [3:0] OP_MUL   = 4'd3;
    localparam logic [3:0] OP_DIV   = 4'd4;
    localparam logic [3:0] OP_POP   = 4'd5;
    localparam logic [3:0] OP_PEEK  = 4'd6;
    localparam logic [3:0] OP_DUP   = 4'd7;
    localparam logic [3:0] OP_SWAP  = 4'd8;
    localparam logic [3:0] OP_CLEAR = 4'd9;

    // Status codes
    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_FULL    = 3'd1;
    localparam logic [2:0] STS_EMPTY   = 3'd2;
    localparam logic [2:0] STS_DIVZERO = 3'd3;
    localparam logic [2:0] STS_UNKNOWN = 3'd4;

    // Q16.16 saturation limits
    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    // Stack memory port request
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    // Multiply/divide unit request and response
    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic sat;
    } md_rsp_t;

endpackage

// ----- rtl/rpn_stack_mem.sv -----
// ----------------------------------------------------------------------------
// rpn_stack_mem
// Stack storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rpn_stack_mem
(
    input  logic                             clk,
    input  rpn_pkg::mem_req_t                req,
    output logic [rpn_pkg::DATA_W-1:0]       rd_data
);

    logic [rpn_pkg::DATA_W-1:0] mem [rpn_pkg::STACK_DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ----- rtl/rpn_muldiv.sv -----
// ----------------------------------------------------------------------------
// rpn_muldiv
// Shared iterative Q16.16 multiply/divide unit: one 34-bit add/subtract per
// cycle, 32 steps, then rescale and saturate.
// ----------------------------------------------------------------------------
module rpn_muldiv
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rpn_pkg::md_req_t            req,
    input  logic [rpn_pkg::DATA_W-1:0]  a,
    input  logic [rpn_pkg::DATA_W-1:0]  b,
    output rpn_pkg::md_rsp_t            rsp,
    output logic [rpn_pkg::DATA_W-1:0]  value
);

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_INIT,
        MD_RUN,
        MD_FIX
    } md_state_t;

    md_state_t          state_reg;
    logic               div_reg;
    logic               neg_reg;
    logic               ovf_reg;
    logic [31:0]        mag_a_reg;
    logic [31:0]        mag_b_reg;
    logic [31:0]        hi_reg;
    logic [31:0]        lo_reg;
    logic [4:0]         step_reg;
    logic               done_reg;
    logic               sat_reg;
    logic [31:0]        value_reg;

    logic [33:0]        add_x;
    logic [33:0]        add_y;
    logic [33:0]        sum;
    logic               qbit;
    logic [31:0]        hi_next;
    logic [31:0]        lo_next;
    logic [47:0]        mag;
    logic               over;
    logic               sat_next;
    logic [31:0]        value_next;

    // Shared adder: add multiplicand for multiply, subtract divisor for divide
    always_comb
    begin
        if (div_reg)
        begin
            add_x = {1'b0, hi_reg, lo_reg[31]};
            add_y = ~{2'b00, mag_b_reg};
        end
        else
        begin
            add_x = {2'b00, hi_reg};
            add_y = lo_reg[0] ? {2'b00, mag_a_reg} : 34'd0;
        end
        sum  = add_x + add_y + {33'd0, div_reg};
        qbit = ~sum[33];
        if (div_reg)
        begin
            hi_next = qbit ? sum[31:0] : add_x[31:0];
            lo_next = {lo_reg[30:0], qbit};
        end
        else
        begin
            hi_next = sum[32:1];
            lo_next = {sum[0], lo_reg[31:1]};
        end
    end

    // Rescale, sign and saturate
    always_comb
    begin
        mag  = div_reg ? {16'd0, lo_reg} : {hi_reg, lo_reg[31:16]};
        over = div_reg & ovf_reg;
        if (neg_reg)
        begin
            sat_next   = over || (mag > 48'h0000_8000_0000);
            value_next = sat_next ? rpn_pkg::Q_MIN : (32'd0 - mag[31:0]);
        end
        else
        begin
            sat_next   = over || (mag > 48'h0000_7FFF_FFFF);
            value_next = sat_next ? rpn_pkg::Q_MAX : mag[31:0];
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            // one-cycle done pulse after the fix-up step
            done_reg <= (state_reg == MD_FIX);
            unique case (state_reg)
                MD_IDLE:
                begin
                    if (req.start)
                    begin
                        div_reg   <= req.is_div;
                        neg_reg   <= a[31] ^ b[31];
                        mag_a_reg <= a[31] ? (32'd0 - a) : a;
                        mag_b_reg <= b[31] ? (32'd0 - b) : b;
                        state_reg <= MD_INIT;
                    end
                end
                MD_INIT:
                begin
                    // quotient wider than 32 bits always saturates
                    ovf_reg  <= ({16'd0, mag_a_reg[31:16]} >= mag_b_reg);
                    step_reg <= 5'd0;
                    if (div_reg)
                    begin
                        hi_reg <= {16'd0, mag_a_reg[31:16]};
                        lo_reg <= {mag_a_reg[15:0], 16'd0};
                    end
                    else
                    begin
                        hi_reg <= 32'd0;
                        lo_reg <= mag_b_reg;
                    end
                    state_reg <= MD_RUN;
                end
                MD_RUN:
                begin
                    hi_reg   <= hi_next;
                    lo_reg   <= lo_next;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd31)
                    begin
                        state_reg <= MD_FIX;
                    end
                end
                MD_FIX:
                begin
                    value_reg <= value_next;
                    sat_reg   <= sat_next;
                    state_reg <= MD_IDLE;
                end
                default:
                begin
                    state_reg <= MD_IDLE;
                end
            endcase
        end
    end

    assign rsp.busy = (state_reg != MD_IDLE);
    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign value    = value_reg;

endmodule

// ----- rtl/rpn_stack_calculator_top.sv -----
// Sequence: push, clear and unknown go from dispatch straight to finish; pop
//   and peek go through ST_POP_GET, dup through ST_DUP_PUT, swap through the
//   swap states; the arithmetic ops fetch both operands, mul and div then wait
//   on the shared unit. One item at a time: the next item can be accepted once
//   the result enters the output register. Mul/div run on the 32-step unit.
// Reset (rst_n, async, active low) empties the stack; no memory clearing pass.
// ----------------------------------------------------------------------------
// rpn_stack_calculator_top
// Reverse-polish calculator on a 128-entry stack of signed Q16.16 values.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand
    input  logic [3:0]  s_tuser,   // [3:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] result_value, [39:32] depth_now
    output logic [3:0]  m_tuser    // [2:0] status, [3] saturated
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_GET_B,
        ST_GET_A,
        ST_EXEC,
        ST_WAIT,
        ST_PUSH_RES,
        ST_POP_GET,
        ST_DUP_PUT,
        ST_SWAP_1,
        ST_SWAP_2,
        ST_SWAP_3,
        ST_FINISH
    } state_t;

    state_t                            state_reg;
    logic [rpn_pkg::CNT_W-1:0]         count_reg;
    logic [3:0]                        op_reg;
    logic [rpn_pkg::DATA_W-1:0]        operand_reg;
    logic [rpn_pkg::DATA_W-1:0]        a_reg;
    logic [rpn_pkg::DATA_W-1:0]        b_reg;
    logic [rpn_pkg::DATA_W-1:0]        tmp_reg;
    logic [rpn_pkg::DATA_W-1:0]        val_reg;
    logic [2:0]                        status_reg;
    logic                              sat_reg;
    logic                              a_empty_reg;
    logic                              b_empty_reg;
    logic                              m_tvalid_reg;
    logic [39:0]                       m_tdata_reg;
    logic [3:0]                        m_tuser_reg;

    rpn_pkg::mem_req_t                 mem_req;
    logic [rpn_pkg::DATA_W-1:0]        rd_data;
    rpn_pkg::md_req_t                  md_req;
    rpn_pkg::md_rsp_t                  md_rsp;
    logic [rpn_pkg::DATA_W-1:0]        md_value;

    logic [rpn_pkg::CNT_W-1:0]         cnt_m1;
    logic [rpn_pkg::CNT_W-1:0]         cnt_m2;
    logic                              is_full;
    logic                              is_empty;
    logic [rpn_pkg::DATA_W-1:0]        b_cur;
    logic [32:0]                       as_sum;
    logic                              as_sat;
    logic [rpn_pkg::DATA_W-1:0]        as_val;

    assign cnt_m1   = count_reg - 1'b1;
    assign cnt_m2   = count_reg - 2'd2;
    assign is_full  = (count_reg == rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH));
    assign is_empty = (count_reg == '0);
    assign b_cur    = b_empty_reg ? '0 : rd_data;

    // Exact add/sub with clamp
    always_comb
    begin
        if (op_reg == rpn_pkg::OP_SUB)
        begin
            as_sum = {a_reg[31], a_reg} - {b_reg[31], b_reg};
        end
        else
        begin
            as_sum = {a_reg[31], a_reg} + {b_reg[31], b_reg};
        end
        as_sat = as_sum[32] ^ as_sum[31];
        as_val = as_sat ? (as_sum[32] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX) : as_sum[31:0];
    end

    // Stack memory requests
    always_comb
    begin
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = count_reg[rpn_pkg::ADDR_W-1:0];
        mem_req.wr_data = val_reg;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = cnt_m1[rpn_pkg::ADDR_W-1:0];
        unique case (state_reg)
            ST_DISPATCH:
            begin
                // top is fetched for any op on a non-empty stack; harmless when unused
                mem_req.rd_en   = !is_empty;
                mem_req.wr_en   = (op_reg == rpn_pkg::OP_PUSH) && !is_full;
                mem_req.wr_data = operand_reg;
            end
            ST_GET_B:
            begin
                mem_req.rd_en = !is_empty;
            end
            ST_PUSH_RES:
            begin
                mem_req.wr_en = 1'b1;
            end
            ST_DUP_PUT:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_data = rd_data;
            end
            ST_SWAP_1:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = cnt_m2[rpn_pkg::ADDR_W-1:0];
            end
            ST_SWAP_2:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cnt_m1[rpn_pkg::ADDR_W-1:0];
                mem_req.wr_data = rd_data;
            end
            ST_SWAP_3:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cnt_m2[rpn_pkg::ADDR_W-1:0];
                mem_req.wr_data = tmp_reg;
            end
            default:
            begin
                mem_req.rd_en = 1'b0;
            end
        endcase
    end

    // Multiply/divide start
    assign md_req.start  = (state_reg == ST_EXEC) &&
                           ((op_reg == rpn_pkg::OP_MUL) || (op_reg == rpn_pkg::OP_DIV));
    assign md_req.is_div = (op_reg == rpn_pkg::OP_DIV);

    rpn_stack_mem u_mem
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    rpn_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .a     (a_reg),
        .b     (b_reg),
        .rsp   (md_rsp),
        .value (md_value)
    );

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // output item taken; ST_FINISH reloads or holds it itself
            if (m_tready && (state_reg != ST_FINISH))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg      <= s_tuser;
                        operand_reg <= s_tdata;
                        val_reg     <= '0;
                        status_reg  <= rpn_pkg::STS_OK;
                        sat_reg     <= 1'b0;
                        a_empty_reg <= 1'b0;
                        b_empty_reg <= 1'b0;
                        state_reg   <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH:
                begin
                    unique case (op_reg)
                        rpn_pkg::OP_PUSH:
                        begin
                            if (is_full)
                                status_reg <= rpn_pkg::STS_FULL;
                            else
                                count_reg <= count_reg + 1'b1;
                            state_reg <= ST_FINISH;
                        end
                        rpn_pkg::OP_ADD, rpn_pkg::OP_SUB,
                        rpn_pkg::OP_MUL, rpn_pkg::OP_DIV:
                        begin
                            if (is_empty)
                                b_empty_reg <= 1'b1;
                            else
                                count_reg <= cnt_m1;
                            state_reg <= ST_GET_B;
                        end
                        rpn_pkg::OP_POP:
                        begin
                            if (is_empty)
                            begin
                                status_reg <= rpn_pkg::STS_EMPTY;
                                state_reg  <= ST_FINISH;
                            end
                            else
                            begin
                                count_reg <= cnt_m1;
                                state_reg <= ST_POP_GET;
                            end
                        end
                        rpn_pkg::OP_PEEK:
                        begin
                            if (is_empty)
                            begin
                                status_reg <= rpn_pkg::STS_EMPTY;
                                state_reg  <= ST_FINISH;
                            end
                            else
                            begin
                                state_reg <= ST_POP_GET;
                            end
                        end
                        rpn_pkg::OP_DUP:
                        begin
                            if (is_empty)
                            begin
                                status_reg <= rpn_pkg::STS_EMPTY;
                                state_reg  <= ST_FINISH;
                            end
                            else if (is_full)
                            begin
                                status_reg <= rpn_pkg::STS_FULL;
                                state_reg  <= ST_FINISH;
                            end
                            else
                            begin
                                state_reg <= ST_DUP_PUT;
                            end
                        end
                        rpn_pkg::OP_SWAP:
                        begin
                            if (count_reg < rpn_pkg::CNT_W'(2))
                            begin
                                status_reg <= rpn_pkg::STS_EMPTY;
                                state_reg  <= ST_FINISH;
                            end
                            else
                            begin
                                state_reg <= ST_SWAP_1;
                            end
                        end
                        rpn_pkg::OP_CLEAR:
                        begin
                            count_reg <= '0;
                            state_reg <= ST_FINISH;
                        end
                        default:
                        begin
                            status_reg <= rpn_pkg::STS_UNKNOWN;
                            state_reg  <= ST_FINISH;
                        end
                    endcase
                end
                ST_GET_B:
                begin
                    b_reg <= b_cur;
                    if ((op_reg == rpn_pkg::OP_DIV) && (b_cur == '0))
                    begin
                        // divisor dropped, left operand stays
                        status_reg <= b_empty_reg ? rpn_pkg::STS_EMPTY : rpn_pkg::STS_DIVZERO;
                        state_reg  <= ST_FINISH;
                    end
                    else
                    begin
                        if (is_empty)
                            a_empty_reg <= 1'b1;
                        else
                            count_reg <= cnt_m1;
                        state_reg <= ST_GET_A;
                    end
                end
                ST_GET_A:
                begin
                    a_reg     <= a_empty_reg ? '0 : rd_data;
                    state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    if ((op_reg == rpn_pkg::OP_ADD) || (op_reg == rpn_pkg::OP_SUB))
                    begin
                        val_reg   <= as_val;
                        sat_reg   <= as_sat;
                        state_reg <= ST_PUSH_RES;
                    end
                    else
                    begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    if (md_rsp.done)
                    begin
                        val_reg   <= md_value;
                        sat_reg   <= md_rsp.sat;
                        state_reg <= ST_PUSH_RES;
                    end
                end
                ST_PUSH_RES:
                begin
                    count_reg  <= count_reg + 1'b1;
                    status_reg <= (a_empty_reg || b_empty_reg) ?
                                  rpn_pkg::STS_EMPTY : rpn_pkg::STS_OK;
                    state_reg  <= ST_FINISH;
                end
                ST_POP_GET:
                begin
                    val_reg   <= rd_data;
                    state_reg <= ST_FINISH;
                end
                ST_DUP_PUT:
                begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= ST_FINISH;
                end
                ST_SWAP_1:
                begin
                    tmp_reg   <= rd_data;
                    state_reg <= ST_SWAP_2;
                end
                ST_SWAP_2:
                begin
                    state_reg <= ST_SWAP_3;
                end
                ST_SWAP_3:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {count_reg, val_reg};
                        m_tuser_reg  <= {sat_reg, status_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    // Entry count never passes the stack depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    // No stack write while waiting for an item
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_req.wr_en)
        else $error("stack write while idle");

    // Shared unit is only started when free
    a_md_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        md_req.start |-> !md_rsp.busy)
        else $error("muldiv started while busy");

    // A unit result only arrives while the sequencer waits for it
    a_md_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> (state_reg == ST_WAIT))
        else $error("muldiv result not awaited");

    // Saturation only comes with an ok or empty status
    a_sat_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[3]) |->
        ((m_tuser[2:0] == rpn_pkg::STS_OK) || (m_tuser[2:0] == rpn_pkg::STS_EMPTY)))
        else $error("saturated flag with wrong status");
`endif

endmodule

// ----- tb/rpn_result_checker.sv -----
// ----------------------------------------------------------------------------
// rpn_result_checker
// Watches both stream channels of the RPN stack calculator. It keeps its own
// copy of the stack, works out the result of every accepted item and compares
// each delivered result, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module rpn_result_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand
    input  logic [3:0]  s_tuser,   // [3:0] operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [31:0] result_value, [39:32] depth_now
    input  logic [3:0]  m_tuser,   // [2:0] status, [3] saturated
    output int          error_count,
    output int          outstanding
);

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  status;
        logic        sat;
        logic [7:0]  depth;
    } calc_result_t;

    localparam longint Q16_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q16_LO = -Q16_HI - 1;
    localparam int     REPORT_LIMIT = 10;

    // Shadow copy of the calculator stack
    logic signed [31:0] shadow_stack [rpn_pkg::STACK_DEPTH];
    int unsigned        shadow_fill;

    calc_result_t expected_results [$];

    // Applies one operation to the shadow stack and returns the result item
    function automatic calc_result_t apply_operation(input logic [3:0] op,
                                                     input logic [31:0] operand);
        calc_result_t res;
        longint       a;
        longint       b;
        longint       r;
        logic         short_stack;
        res = '0;
        short_stack = 1'b0;
        case (op)
            rpn_pkg::OP_PUSH:
            begin
                if (shadow_fill < rpn_pkg::STACK_DEPTH)
                begin
                    shadow_stack[shadow_fill] = operand;
                    shadow_fill++;
                end
                else
                    res.status = rpn_pkg::STS_FULL;
            end
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV:
            begin
                // right operand b is the top, left operand a below it
                b = 0;
                if (shadow_fill == 0)
                    short_stack = 1'b1;
                else
                begin
                    shadow_fill--;
                    b = shadow_stack[shadow_fill];
                end
                if (op == rpn_pkg::OP_DIV && b == 0)
                    res.status = short_stack ? rpn_pkg::STS_EMPTY : rpn_pkg::STS_DIVZERO;
                else
                begin
                    a = 0;
                    if (shadow_fill == 0)
                        short_stack = 1'b1;
                    else
                    begin
                        shadow_fill--;
                        a = shadow_stack[shadow_fill];
                    end
                    case (op)
                        rpn_pkg::OP_ADD: r = a + b;
                        rpn_pkg::OP_SUB: r = a - b;
                        rpn_pkg::OP_MUL: r = (a * b) / 65536;
                        default:         r = (a * 65536) / b;
                    endcase
                    // clamp to Q16.16 range
                    if (r > Q16_HI)
                    begin
                        r = Q16_HI;
                        res.sat = 1'b1;
                    end
                    else if (r < Q16_LO)
                    begin
                        r = Q16_LO;
                        res.sat = 1'b1;
                    end
                    res.value = r[31:0];
                    shadow_stack[shadow_fill] = r[31:0];
                    shadow_fill++;
                    if (short_stack)
                        res.status = rpn_pkg::STS_EMPTY;
                end
            end
            rpn_pkg::OP_POP:
            begin
                if (shadow_fill == 0)
                    res.status = rpn_pkg::STS_EMPTY;
                else
                begin
                    shadow_fill--;
                    res.value = shadow_stack[shadow_fill];
                end
            end
            rpn_pkg::OP_PEEK:
            begin
                if (shadow_fill == 0)
                    res.status = rpn_pkg::STS_EMPTY;
                else
                    res.value = shadow_stack[shadow_fill - 1];
            end
            rpn_pkg::OP_DUP:
            begin
                if (shadow_fill == 0)
                    res.status = rpn_pkg::STS_EMPTY;
                else if (shadow_fill >= rpn_pkg::STACK_DEPTH)
                    res.status = rpn_pkg::STS_FULL;
                else
                begin
                    shadow_stack[shadow_fill] = shadow_stack[shadow_fill - 1];
                    shadow_fill++;
                end
            end
            rpn_pkg::OP_SWAP:
            begin
                if (shadow_fill < 2)
                    res.status = rpn_pkg::STS_EMPTY;
                else
                begin
                    a = shadow_stack[shadow_fill - 1];
                    shadow_stack[shadow_fill - 1] = shadow_stack[shadow_fill - 2];
                    shadow_stack[shadow_fill - 2] = a[31:0];
                end
            end
            rpn_pkg::OP_CLEAR:
                shadow_fill = 0;
            default:
                res.status = rpn_pkg::STS_UNKNOWN;
        endcase
        res.depth = shadow_fill[7:0];
        return res;
    endfunction

    initial
    begin
        error_count = 0;
        outstanding = 0;
        shadow_fill = 0;
    end

    // Compare delivered results first, then log the newly accepted item
    always @(posedge clk)
    begin
        calc_result_t got;
        calc_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.value  = m_tdata[31:0];
                got.depth  = m_tdata[39:32];
                got.status = m_tuser[2:0];
                got.sat    = m_tuser[3];
                if (expected_results.size() == 0)
                begin
                    if (error_count < REPORT_LIMIT)
                        $display("%0t: unexpected result: value %h status %0d sat %0b depth %0d",
                                 $realtime, got.value, got.status, got.sat, got.depth);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value || got.status !== want.status ||
                        got.sat !== want.sat || got.depth !== want.depth)
                    begin
                        if (error_count < REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch: expected value %h status %0d sat %0b depth %0d",
                                     $realtime, want.value, want.status, want.sat, want.depth);
                            $display("    got value %h status %0d sat %0b depth %0d",
                                     got.value, got.status, got.sat, got.depth);
                        end
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_operation(s_tuser, s_tdata));
            outstanding = expected_results.size();
        end
    end

endmodule

// ----- tb/rpn_stack_calculator_top_test.sv -----
// ----------------------------------------------------------------------------
// rpn_stack_calculator_top_test
// Drives operation items into the RPN stack calculator: a directed opening
// over empty, saturating and divide-by-zero cases, then random push and
// arithmetic sequences with noise. Both stream sides idle at random, and the
// result side holds off once for a long stretch. A checker module predicts
// and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_top_test;

    localparam int         CYCLE_LIMIT   = 400_000;
    localparam int         RANDOM_ITEMS  = 900;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         DRAIN_CYCLES  = 60;
    localparam logic [3:0] OP_UNKNOWN_LO = 4'd10;
    localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;
    localparam logic [3:0][3:0] ARITH_OPS = {rpn_pkg::OP_DIV, rpn_pkg::OP_MUL,
                                             rpn_pkg::OP_SUB, rpn_pkg::OP_ADD};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [3:0]  m_tuser;

    int   error_count;
    int   outstanding;
    int   cycle_count;
    int   items_sent;
    int   burst_left;
    logic long_hold_due;

    rpn_stack_calculator_top DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rpn_result_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial
        clk = 1'b0;

    always #2 clk = ~clk;

    // Q16.16 operand mix: full range, small, mid-size and corner values
    function automatic logic [31:0] pick_q16();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            2: v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            3:
            begin
                case ($urandom_range(0, 5))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h0001_0000;
                    default: v = 32'h0000_0001;
                endcase
            end
            default: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        endcase
        return v;
    endfunction

    // Offer one item, with bursts separated by random gaps
    task automatic send_item(input logic [3:0] op, input logic [31:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // Result side: changing stall patterns plus one long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        int phase;
        m_tready = 1'b0;
        mode = 0;
        mode_left = 0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_due)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold_due = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            phase++;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 7) != 0);
                default: m_tready <= ((phase % 5) < 2);
            endcase
        end
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        int  n;
        int  start_count;
        bit  filled;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        items_sent = 0;
        burst_left = 0;
        long_hold_due = 1'b0;
        filled = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty-stack cases first
        send_item(rpn_pkg::OP_POP,   32'h1234_5678);
        send_item(rpn_pkg::OP_PEEK,  32'hFFFF_FFFF);
        send_item(rpn_pkg::OP_DUP,   32'h0000_0000);
        send_item(rpn_pkg::OP_DIV,   32'hA5A5_A5A5);
        send_item(rpn_pkg::OP_ADD,   32'h5A5A_5A5A);
        send_item(rpn_pkg::OP_SWAP,  32'h0000_0000);
        send_item(rpn_pkg::OP_CLEAR, 32'hFFFF_FFFF);
        // saturating arithmetic, divide by zero, stack ops and unknown codes
        send_item(rpn_pkg::OP_PUSH,  32'h7FFF_FFFF);
        send_item(rpn_pkg::OP_PUSH,  32'h7FFF_FFFF);
        send_item(rpn_pkg::OP_ADD,   32'h0000_0000);
        send_item(rpn_pkg::OP_PUSH,  32'h8000_0000);
        send_item(rpn_pkg::OP_MUL,   32'h0000_0000);
        send_item(rpn_pkg::OP_PUSH,  32'h0000_0000);
        send_item(rpn_pkg::OP_DIV,   32'h0000_0000);
        send_item(rpn_pkg::OP_PUSH,  32'hFFFF_FFFF);
        send_item(rpn_pkg::OP_DIV,   32'h0000_0000);
        send_item(rpn_pkg::OP_PUSH,  32'h0001_8000);
        send_item(rpn_pkg::OP_SWAP,  32'h0000_0000);
        send_item(rpn_pkg::OP_SUB,   32'h0000_0000);
        send_item(rpn_pkg::OP_DUP,   32'h0000_0000);
        send_item(rpn_pkg::OP_PEEK,  32'h0000_0000);
        send_item(rpn_pkg::OP_POP,   32'h0000_0000);
        send_item(OP_UNKNOWN_LO, 32'hFFFF_FFFF);
        send_item(OP_UNKNOWN_HI, 32'h0000_0000);
        send_item(rpn_pkg::OP_CLEAR, 32'h0000_0000);

        // Random part; the result side holds off early on
        long_hold_due = 1'b1;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            if ((!filled && items_sent - start_count > 400) || $urandom_range(0, 199) == 0)
            begin
                // fill the stack past full, then empty it
                filled = 1'b1;
                send_item(rpn_pkg::OP_CLEAR, $urandom);
                repeat (rpn_pkg::STACK_DEPTH + 2) send_item(rpn_pkg::OP_PUSH, pick_q16());
                send_item(rpn_pkg::OP_DUP, $urandom);
                send_item(rpn_pkg::OP_SWAP, $urandom);
                send_item(rpn_pkg::OP_MUL, $urandom);
                send_item(rpn_pkg::OP_PUSH, pick_q16());
                send_item(rpn_pkg::OP_PUSH, pick_q16());
                send_item(rpn_pkg::OP_CLEAR, $urandom);
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1:
                    begin
                        // noise
                        repeat ($urandom_range(1, 4))
                            send_item(4'($urandom_range(rpn_pkg::OP_PUSH, OP_UNKNOWN_HI)),
                                      $urandom);
                    end
                    2:
                    begin
                        // short operand list
                        send_item(rpn_pkg::OP_CLEAR, $urandom);
                        repeat ($urandom_range(0, 1)) send_item(rpn_pkg::OP_PUSH, pick_q16());
                        send_item(ARITH_OPS[2'($urandom_range(0, 3))], $urandom);
                    end
                    3:
                    begin
                        // pop a run of items, possibly past empty
                        repeat ($urandom_range(1, 8)) send_item(rpn_pkg::OP_POP, $urandom);
                    end
                    4:
                        send_item(rpn_pkg::OP_CLEAR, $urandom);
                    default:
                    begin
                        // well-formed expression
                        n = $urandom_range(2, 6);
                        repeat (n) send_item(rpn_pkg::OP_PUSH, pick_q16());
                        repeat (n - 1)
                        begin
                            case ($urandom_range(0, 9))
                                0: send_item(rpn_pkg::OP_DUP, $urandom);
                                1: send_item(rpn_pkg::OP_SWAP, $urandom);
                                2: send_item(rpn_pkg::OP_PEEK, $urandom);
                                default: ;
                            endcase
                            send_item(ARITH_OPS[2'($urandom_range(0, 3))], $urandom);
                        end
                        if ($urandom_range(0, 1) == 1)
                            send_item(rpn_pkg::OP_POP, $urandom);
                    end
                endcase
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
